[hw/rtl/mm_pkg.sv]
// Package for the matrix multiply block: payload types, codes and the FSM states.
package mm_pkg;

  localparam int unsigned MaxDim = 8;
  localparam int unsigned ElemW = 16;
  localparam int unsigned ProdW = 32;
  localparam int unsigned AccW  = 38;

  typedef enum logic [1:0] {
    ACT_WRITE_A = 2'd0,
    ACT_WRITE_B = 2'd1,
    ACT_COMPUTE = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_ROWS_A = 2'd0,
    REG_INNER  = 2'd1,
    REG_COLS_B = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MAC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [2:0]        row_index;
    logic [2:0]        col_index;
    logic signed [15:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         out_row;
    logic [2:0]         out_col;
    logic signed [31:0] product_value;
    logic               last_element;
  } out_item_t;

  // Control handed to the cell chain by the sequencer.
  typedef struct packed {
    logic clear;
    logic step;
    logic shift;
  } cell_ctl_t;

  function automatic logic signed [ProdW-1:0] sat32(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] hi;
    logic signed [AccW-1:0] lo;
    hi = AccW'(64'sh7FFF_FFFF);
    lo = -AccW'(64'sh8000_0000);
    if (v > hi) sat32 = 32'sh7FFF_FFFF;
    else if (v < lo) sat32 = 32'sh8000_0000;
    else sat32 = v[ProdW-1:0];
  endfunction

  function automatic logic [3:0] eff_size(input logic [3:0] v, input logic [3:0] maxd);
    if (v == 4'd0) eff_size = 4'd1;
    else if (v > maxd) eff_size = maxd;
    else eff_size = v;
  endfunction

endpackage

[hw/rtl/mm_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
module mm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[hw/rtl/mm_cell.sv]
// One multiply-accumulate cell: multiplies a pair, accumulates, passes its sum down the chain.
module mm_cell (
  input  logic                                    clk,
  input  mm_pkg::cell_ctl_t                       ctl,
  input  logic signed [mm_pkg::ElemW-1:0]         a_in,
  input  logic signed [mm_pkg::ElemW-1:0]         b_in,
  input  logic signed [mm_pkg::AccW-1:0]          acc_in,
  output logic signed [mm_pkg::AccW-1:0]          acc
);
  logic signed [mm_pkg::ProdW-1:0] prod_r;
  logic                            pv_r;
  logic signed [mm_pkg::AccW-1:0]  acc_r;

  // product registered, then accumulated; on read-out the sum moves one cell down
  always_ff @(posedge clk) begin
    prod_r <= a_in * b_in;
    pv_r   <= ctl.step;
    if (ctl.clear) acc_r <= '0;
    else if (ctl.shift) acc_r <= acc_in;
    else if (pv_r) acc_r <= acc_r + mm_pkg::AccW'(prod_r);
  end

  assign acc = acc_r;
endmodule

[hw/rtl/matrix_multiply.sv]
// Matrix multiply top level: stores, sequencer, cell chain and result shift-out.
// A or B load: one request per cycle while idle, busy stays low, no result.
// Compute (sizes after clamping): busy through every row of C; per row of C
//   the k-walk reads inner_size A/B pairs, a drain follows, then cols_b results are emitted.
// The next request is taken with the last result.
// rst_n is synchronous, active low; sizes reset to 8, stores hold no reset value.
module matrix_multiply (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  mm_pkg::in_item_t  in_item,
  output logic              out_valid,
  output mm_pkg::out_item_t out_item,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [3:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);
  localparam int unsigned Depth = mm_pkg::MaxDim * mm_pkg::MaxDim;
  localparam int unsigned AW    = 6;
  localparam logic [3:0]  MaxD  = 4'(mm_pkg::MaxDim);

  logic [3:0] rows_a_r, inner_r, cols_b_r;
  logic [3:0] na, nk, nb;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r <= 4'd8;
      inner_r  <= 4'd8;
      cols_b_r <= 4'd8;
    end else if (cfg_wr) begin
      unique case (mm_pkg::reg_idx_t'(cfg_paddr[3:2]))
        mm_pkg::REG_ROWS_A: rows_a_r <= cfg_pwdata[3:0];
        mm_pkg::REG_INNER:  inner_r  <= cfg_pwdata[3:0];
        mm_pkg::REG_COLS_B: cols_b_r <= cfg_pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (mm_pkg::reg_idx_t'(cfg_paddr[3:2]))
      mm_pkg::REG_ROWS_A: cfg_prdata = {28'd0, rows_a_r};
      mm_pkg::REG_INNER:  cfg_prdata = {28'd0, inner_r};
      mm_pkg::REG_COLS_B: cfg_prdata = {28'd0, cols_b_r};
      default:            cfg_prdata = '0;
    endcase
  end

  assign na = mm_pkg::eff_size(rows_a_r, MaxD);
  assign nk = mm_pkg::eff_size(inner_r, MaxD);
  assign nb = mm_pkg::eff_size(cols_b_r, MaxD);

  // request decode
  mm_pkg::state_t state_r, state_nxt;
  logic accept;
  logic we_a, we_b;
  logic [AW-1:0] waddr;

  assign accept = start & ~busy;
  assign waddr  = {in_item.row_index, in_item.col_index};
  assign we_a = accept && in_item.action == mm_pkg::ACT_WRITE_A
                && {1'b0, in_item.row_index} < na && {1'b0, in_item.col_index} < nk;
  assign we_b = accept && in_item.action == mm_pkg::ACT_WRITE_B
                && {1'b0, in_item.row_index} < nk && {1'b0, in_item.col_index} < nb;

  // A is one RAM; B is one RAM per column so every cell reads its own column
  logic [2:0] i_r, i_nxt, k_r, k_nxt, e_r, e_nxt;
  logic signed [15:0] a_rd;
  logic signed [15:0] b_rd [mm_pkg::MaxDim];

  mm_ram #(.WIDTH(16), .DEPTH(Depth)) u_ram_a (
    .clk(clk), .we(we_a), .waddr(waddr), .wdata(in_item.element_value),
    .raddr({i_r, k_r}), .rdata(a_rd)
  );

  logic signed [mm_pkg::AccW-1:0] acc [mm_pkg::MaxDim];
  mm_pkg::cell_ctl_t ctl;
  mm_pkg::cell_ctl_t cell_ctl;
  logic step_r;

  assign cell_ctl = '{clear: ctl.clear, step: step_r, shift: ctl.shift};

  for (genvar j = 0; j < mm_pkg::MaxDim; j++) begin : g_col
    logic signed [mm_pkg::AccW-1:0] acc_next;
    if (j == mm_pkg::MaxDim - 1) begin : g_end
      assign acc_next = '0;
    end else begin : g_mid
      assign acc_next = acc[j+1];
    end
    mm_ram #(.WIDTH(16), .DEPTH(mm_pkg::MaxDim)) u_ram_b (
      .clk(clk),
      .we(we_b && in_item.col_index == 3'(j)),
      .waddr(in_item.row_index),
      .wdata(in_item.element_value),
      .raddr(k_r),
      .rdata(b_rd[j])
    );
    mm_cell u_cell (
      .clk(clk), .ctl(cell_ctl),
      .a_in(a_rd), .b_in(b_rd[j]), .acc_in(acc_next), .acc(acc[j])
    );
  end

  // Sequencer: per row, walk k (reads), drain, then shift out nb results.
  logic [2:0] drain_r, drain_nxt;
  always_comb begin
    state_nxt = state_r;
    i_nxt = i_r; k_nxt = k_r; e_nxt = e_r; drain_nxt = drain_r;
    ctl.clear = 1'b0;
    ctl.step  = 1'b0;
    ctl.shift = 1'b0;
    unique case (state_r)
      mm_pkg::ST_IDLE: begin
        if (accept && in_item.action == mm_pkg::ACT_COMPUTE) begin
          state_nxt = mm_pkg::ST_READ;
          i_nxt = '0; k_nxt = '0; ctl.clear = 1'b1;
        end
      end
      mm_pkg::ST_READ: begin
        ctl.step = 1'b1;
        if ({1'b0, k_r} == nk - 4'd1) begin
          state_nxt = mm_pkg::ST_MAC;
          drain_nxt = '0;
        end else k_nxt = k_r + 3'd1;
      end
      mm_pkg::ST_MAC: begin
        drain_nxt = drain_r + 3'd1;
        if (drain_r == 3'd2) begin
          state_nxt = mm_pkg::ST_DONE;
          e_nxt = '0;
        end
      end
      mm_pkg::ST_DONE: begin
        ctl.shift = 1'b1;
        e_nxt = e_r + 3'd1;
        if ({1'b0, e_r} == nb - 4'd1) begin
          if ({1'b0, i_r} == na - 4'd1) state_nxt = mm_pkg::ST_IDLE;
          else begin
            state_nxt = mm_pkg::ST_READ;
            i_nxt = i_r + 3'd1; k_nxt = '0; ctl.clear = 1'b1;
          end
        end
      end
      default: state_nxt = mm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mm_pkg::ST_IDLE;
      step_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= ctl.step; // RAM read latency
    end
    i_r <= i_nxt; k_r <= k_nxt; e_r <= e_nxt; drain_r <= drain_nxt;
  end

  assign busy = state_r != mm_pkg::ST_IDLE;

  // result register; cell 0 holds the current column during shift-out
  logic              ov_r;
  mm_pkg::out_item_t oi_r;
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else ov_r <= state_r == mm_pkg::ST_DONE;
    oi_r.out_row       <= i_r;
    oi_r.out_col       <= e_r;
    oi_r.product_value <= mm_pkg::sat32(acc[0]);
    oi_r.last_element  <= {1'b0, i_r} == na - 4'd1 && {1'b0, e_r} == nb - 4'd1;
  end
  assign out_valid = ov_r;
  assign out_item  = oi_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !(we_a || we_b)) else $error("store written while busy");
  a_out_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result outside compute");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.last_element) |=> !out_valid) else $error("result after last");
endmodule
